// File: sv/pbs_pkg.sv
package pbs_pkg;

	// Fixed geometry of the store and of one field.
	localparam int unsigned WORD_BITS        = 32;
	localparam int unsigned FIELDS_PER_GROUP = 3;
	localparam int unsigned DEF_WORDS        = 1024;
	localparam int unsigned MAX_FIELD_WIDTH  = 21;
	localparam int unsigned FIELD_WIDTH_RST  = 8;

	// Port widths.
	localparam int unsigned CFG_W   = 5;
	localparam int unsigned INDEX_W = 15;
	localparam int unsigned FIELD_W = 21;
	localparam int unsigned RESULT_W = 63;

	// Internal widths: a field number of a whole group and a bit position.
	localparam int unsigned FNUM_W = 17;
	localparam int unsigned BITPOS_W = 22;

	typedef enum logic [1:0] {
		OP_WRITE      = 2'd0,
		OP_READ       = 2'd1,
		OP_READ_GROUP = 2'd2,
		OP_COPY       = 2'd3
	} op_t;

	// Control of the single word port.
	typedef struct packed {
		logic en;
		logic we;
	} ram_ctl_t;

endpackage

// File: sv/packed_bitfield_store_unit.sv
// Channel   | Direction | Handshake            | Carries
// ----------+-----------+----------------------+-------------------------------------------
// input     | in        | in_valid / in_stall  | operation, field_index, source_index,
//           |           |                      | write_value
// result    | out       | out_valid / out_stall| read_value, range_error
// config    | in        | cfg_valid / cfg_ready| cfg_data (field width)
//
// One item is handled at a time by a small sequencer around one multiplier and one word port.
// Each field write, and each field of a group copy, goes through its own read-modify-write;
// a field that straddles two words needs a second word access in each direction.
// The single port of the word memory reads or writes one word a cycle.
// Reset clears only control state and sets the field width to 8; the words are not cleared.
// A result waiting on out_stall does not hold up the next transfer in; a second result waits
// in the sequencer until the output register is free.
module packed_bitfield_store_unit #(
	parameter int unsigned WORDS = pbs_pkg::DEF_WORDS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        operation,
	input  logic [pbs_pkg::INDEX_W-1:0]       field_index,
	input  logic [pbs_pkg::INDEX_W-1:0]       source_index,
	input  logic [pbs_pkg::FIELD_W-1:0]       write_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pbs_pkg::RESULT_W-1:0]      read_value,
	output logic                              range_error,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pbs_pkg::CFG_W-1:0]         cfg_data
);
	import pbs_pkg::*;

	localparam int unsigned AW = $clog2(WORDS);
	localparam logic [BITPOS_W-1:0] STORE_LIMIT = BITPOS_W'(WORDS * WORD_BITS);
	localparam logic [1:0] LAST_FIELD = 2'(FIELDS_PER_GROUP - 1);

	// One-hot sequencer states.
	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_CHKD = 11'b000_0000_0010,
		S_CHKS = 11'b000_0000_0100,
		S_ADDR = 11'b000_0000_1000,
		S_RD0  = 11'b000_0001_0000,
		S_RD1  = 11'b000_0010_0000,
		S_CAP  = 11'b000_0100_0000,
		S_EXEC = 11'b000_1000_0000,
		S_WR0  = 11'b001_0000_0000,
		S_WR1  = 11'b010_0000_0000,
		S_DONE = 11'b100_0000_0000
	} state_t;

	state_t                state_q;
	op_t                   op_q;
	logic [CFG_W-1:0]      width_q;
	logic [CFG_W-1:0]      w_q;
	logic [FNUM_W-1:0]     basd_q;
	logic [FNUM_W-1:0]     bass_q;
	logic [FIELD_W-1:0]    val_q;
	logic [1:0]            k_q;
	logic                  wr_phase_q;
	logic                  err_q;
	logic [BITPOS_W-1:0]   start_q;
	logic [WORD_BITS-1:0]  w0_q;
	logic [WORD_BITS-1:0]  w1_q;
	logic [FIELD_W-1:0]    fld_q;
	logic [RESULT_W-1:0]   res_q;
	logic                  out_valid_q;
	logic [RESULT_W-1:0]   read_value_q;
	logic                  range_error_q;

	logic                  in_xfer;
	logic [CFG_W-1:0]      weff;
	logic                  op_is_group;
	logic [FNUM_W-1:0]     dst_ext;
	logic [FNUM_W-1:0]     src_ext;
	logic [FNUM_W-1:0]     mul_a;
	logic [BITPOS_W-1:0]   mul_p;
	logic                  over;
	logic [FNUM_W-1:0]     cur_idx;
	logic [AW-1:0]         word0;
	logic [AW-1:0]         word1;
	logic [4:0]            off;
	logic                  two;
	logic [5:0]            shamt;
	logic [FIELD_W-1:0]    fmask;
	logic [2*WORD_BITS-1:0] pair;
	logic [2*WORD_BITS-1:0] mask64;
	logic [2*WORD_BITS-1:0] val64;
	logic [2*WORD_BITS-1:0] merged;
	logic [FIELD_W-1:0]    fld;
	logic [FIELD_W-1:0]    wv;
	logic                  last_field;
	logic                  out_free;
	ram_ctl_t              ram_ctl;
	logic [AW-1:0]         ram_addr;
	logic [WORD_BITS-1:0]  ram_wdata;
	logic [WORD_BITS-1:0]  ram_rdata;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	// A width of zero behaves as one, anything above the maximum as the maximum.
	always_comb begin
		if (width_q == '0) begin
			weff = CFG_W'(1);
		end else if (width_q > CFG_W'(MAX_FIELD_WIDTH)) begin
			weff = CFG_W'(MAX_FIELD_WIDTH);
		end else begin
			weff = width_q;
		end
	end

	// Group operations address field three times the group index.
	assign op_is_group = (op_t'(operation) == OP_READ_GROUP) || (op_t'(operation) == OP_COPY);
	assign dst_ext = FNUM_W'(field_index);
	assign src_ext = FNUM_W'(source_index);

	// The current field: the source group during the read half of a copy, else the destination.
	assign cur_idx = ((op_q == OP_COPY) && !wr_phase_q) ? (bass_q + FNUM_W'(k_q))
	                                                    : (basd_q + FNUM_W'(k_q));

	// The shared multiplier gives the end bit of a range check or the start bit of a field.
	always_comb begin
		case (state_q)
			S_CHKD: begin
				mul_a = (op_q == OP_READ_GROUP || op_q == OP_COPY)
				        ? basd_q + FNUM_W'(FIELDS_PER_GROUP) : basd_q + FNUM_W'(1);
			end
			S_CHKS: mul_a = bass_q + FNUM_W'(FIELDS_PER_GROUP);
			default: mul_a = cur_idx;
		endcase
	end
	assign mul_p = {{(BITPOS_W-FNUM_W){1'b0}}, mul_a} * {{(BITPOS_W-CFG_W){1'b0}}, w_q};
	assign over  = (mul_p > STORE_LIMIT);

	// Position of the current field within its word pair.
	assign word0 = start_q[AW+4:5];
	assign word1 = word0 + AW'(1);
	assign off   = start_q[4:0];
	assign two   = ({1'b0, off} + {1'b0, w_q}) > 6'(WORD_BITS);
	assign shamt = 6'(7'(2 * WORD_BITS) - {2'b0, off} - {2'b0, w_q});
	assign fmask = FIELD_W'((22'd1 << w_q) - 22'd1);
	assign pair  = {w0_q, w1_q};

	// Extraction and insertion; bits of the second word fall away when the field fits in one.
	assign fld    = FIELD_W'(pair >> shamt) & fmask;
	assign wv     = ((op_q == OP_COPY) ? fld_q : val_q) & fmask;
	assign mask64 = {{(2*WORD_BITS-FIELD_W){1'b0}}, fmask} << shamt;
	assign val64  = {{(2*WORD_BITS-FIELD_W){1'b0}}, wv} << shamt;
	assign merged = (pair & ~mask64) | val64;

	assign last_field = (op_q == OP_WRITE) || (op_q == OP_READ) || (k_q == LAST_FIELD);

	// Word port requests.
	always_comb begin
		ram_ctl   = '0;
		ram_addr  = word0;
		ram_wdata = w0_q;
		case (state_q)
			S_RD0: ram_ctl.en = 1'b1;
			S_RD1: begin
				ram_ctl.en = two;
				ram_addr   = word1;
			end
			S_WR0: begin
				ram_ctl.en = 1'b1;
				ram_ctl.we = 1'b1;
			end
			S_WR1: begin
				ram_ctl.en = 1'b1;
				ram_ctl.we = 1'b1;
				ram_addr   = word1;
				ram_wdata  = w1_q;
			end
			default: ram_ctl = '0;
		endcase
	end

	pbs_word_ram #(
		.WORDS (WORDS)
	) u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Configuration register: written whenever the port transfers, as it is only used while idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(FIELD_WIDTH_RST);
		end else if (cfg_valid && cfg_ready) begin
			width_q <= cfg_data;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A new result is loaded as the old one leaves, so the register is never empty
			// for a cycle in between.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_CHKD;
					end
				end
				S_CHKD: begin
					if (over) begin
						state_q <= S_DONE;
					end else if (op_q == OP_COPY) begin
						state_q <= S_CHKS;
					end else begin
						state_q <= S_ADDR;
					end
				end
				S_CHKS: state_q <= over ? S_DONE : S_ADDR;
				S_ADDR: state_q <= S_RD0;
				S_RD0:  state_q <= S_RD1;
				S_RD1:  state_q <= S_CAP;
				S_CAP:  state_q <= S_EXEC;
				S_EXEC: begin
					if (wr_phase_q) begin
						state_q <= S_WR0;
					end else if (op_q == OP_COPY || !last_field) begin
						state_q <= S_ADDR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WR0: begin
					if (two) begin
						state_q <= S_WR1;
					end else begin
						state_q <= last_field ? S_DONE : S_ADDR;
					end
				end
				S_WR1: state_q <= last_field ? S_DONE : S_ADDR;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the item in progress.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					op_q       <= op_t'(operation);
					w_q        <= weff;
					basd_q     <= op_is_group ? (dst_ext << 1) + dst_ext : dst_ext;
					bass_q     <= (src_ext << 1) + src_ext;
					val_q      <= write_value;
					k_q        <= '0;
					wr_phase_q <= (op_t'(operation) == OP_WRITE);
					err_q      <= 1'b0;
					res_q      <= '0;
				end
			end
			S_CHKD, S_CHKS: begin
				if (over) begin
					err_q <= 1'b1;
				end
			end
			S_ADDR: start_q <= mul_p;
			S_RD1:  w0_q <= ram_rdata;
			S_CAP:  w1_q <= ram_rdata;
			S_EXEC: begin
				if (wr_phase_q) begin
					w0_q <= merged[2*WORD_BITS-1:WORD_BITS];
					w1_q <= merged[WORD_BITS-1:0];
				end else if (op_q == OP_COPY) begin
					fld_q      <= fld;
					wr_phase_q <= 1'b1;
				end else begin
					// Earlier fields move up, so the first lands in the high bits.
					res_q <= (res_q << w_q) | RESULT_W'(fld);
					if (!last_field) begin
						k_q <= k_q + 2'd1;
					end
				end
			end
			S_WR0: begin
				if (!two && !last_field) begin
					k_q        <= k_q + 2'd1;
					wr_phase_q <= 1'b0;
				end
			end
			S_WR1: begin
				if (!last_field) begin
					k_q        <= k_q + 2'd1;
					wr_phase_q <= 1'b0;
				end
			end
			S_DONE: begin
				if (out_free) begin
					read_value_q  <= err_q ? '0 : res_q;
					range_error_q <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign range_error = range_error_q;

endmodule

// File: sv/pbs_word_ram.sv
module pbs_word_ram #(
	parameter int unsigned WORDS = pbs_pkg::DEF_WORDS,
	localparam int unsigned AW = $clog2(WORDS)
) (
	input  logic                           clk,
	input  pbs_pkg::ram_ctl_t              ctl,
	input  logic [AW-1:0]                  addr,
	input  logic [pbs_pkg::WORD_BITS-1:0]  wdata,
	output logic [pbs_pkg::WORD_BITS-1:0]  rdata
);
	import pbs_pkg::*;

	logic [WORD_BITS-1:0] words_q [WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	// Single port: a cycle either writes or reads, read data is registered.
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.we) begin
				words_q[addr] <= wdata;
			end else begin
				rdata_q <= words_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/pbs_checker.sv
module pbs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [pbs_pkg::RESULT_W-1:0]  read_value,
	input logic                          range_error
);
	import pbs_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(read_value) && $stable(range_error))
		else $error("result changed while stalled");

	// A refused access returns no data.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> read_value == '0)
		else $error("range error with nonzero read value");

	// The unit takes one item at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in progress");

	// No result can be produced in the cycle straight after a transfer in.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind packed_bitfield_store_unit pbs_checker u_pbs_checker (.*);
